### sv/pgmhb_pkg.sv
// shared types, constants and the cordic angle table for the polar grid binner
package pgmhb_pkg;

  localparam int NUM_RINGS_DEF   = 20;
  localparam int NUM_SECTORS_DEF = 60;

  localparam int RADIUS_W    = 18;
  localparam int HEIGHT_W    = 17;
  localparam int COORD_W     = 20;
  localparam int ZS_W        = 21;
  localparam int DEPTH_W     = 20;
  localparam int RING_OUT_W  = 5;
  localparam int SECT_OUT_W  = 6;
  localparam int GRID_ADDR_W = 14;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 18;

  localparam int CORDIC_STEPS = 30;
  localparam int TURN_W       = 30;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RADIUS    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_HEIGHT = 1'd1;

  localparam logic [RADIUS_W-1:0] MAX_RADIUS_RST    = 18'd80000;
  localparam logic [HEIGHT_W-1:0] SENSOR_HEIGHT_RST = 17'd2000;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    K_NONE,
    K_CLEAR,
    K_ADD,
    K_READ
  } job_kind_t;

  typedef struct packed {
    job_kind_t                kind;
    logic [RING_OUT_W-1:0]    ring;
    logic [SECT_OUT_W-1:0]    sector;
    logic [GRID_ADDR_W-1:0]   addr;
    logic signed [ZS_W-1:0]   zs;
    logic [DEPTH_W-1:0]       depth;
  } job_t;

  function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] i);
    logic [TURN_W-1:0] t;
    case (i)
      5'd0:  t = 30'd536870912;
      5'd1:  t = 30'd316933405;
      5'd2:  t = 30'd167458907;
      5'd3:  t = 30'd85004756;
      5'd4:  t = 30'd42667331;
      5'd5:  t = 30'd21354465;
      5'd6:  t = 30'd10679838;
      5'd7:  t = 30'd5340245;
      5'd8:  t = 30'd2670163;
      5'd9:  t = 30'd1335087;
      5'd10: t = 30'd667544;
      5'd11: t = 30'd333772;
      5'd12: t = 30'd166886;
      5'd13: t = 30'd83443;
      5'd14: t = 30'd41722;
      5'd15: t = 30'd20861;
      5'd16: t = 30'd10430;
      5'd17: t = 30'd5215;
      5'd18: t = 30'd2608;
      5'd19: t = 30'd1304;
      5'd20: t = 30'd652;
      5'd21: t = 30'd326;
      5'd22: t = 30'd163;
      5'd23: t = 30'd81;
      5'd24: t = 30'd41;
      5'd25: t = 30'd20;
      5'd26: t = 30'd10;
      5'd27: t = 30'd5;
      5'd28: t = 30'd3;
      5'd29: t = 30'd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

### sv/pgmhb_front.sv
// front end: takes items, works out ring, sector, depth and bin address, queues jobs
module pgmhb_front #(
  parameter int NUM_RINGS   = pgmhb_pkg::NUM_RINGS_DEF,
  parameter int NUM_SECTORS = pgmhb_pkg::NUM_SECTORS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pgmhb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pgmhb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            operation,
  input  logic signed [pgmhb_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [pgmhb_pkg::COORD_W-1:0]  y_coord,
  input  logic signed [pgmhb_pkg::COORD_W-1:0]  z_coord,
  input  logic [pgmhb_pkg::RING_OUT_W-1:0]      ring_select,
  input  logic [pgmhb_pkg::SECT_OUT_W-1:0]      sector_select,
  output logic                                  push,
  input  logic                                  full,
  output pgmhb_pkg::job_t                       job
);
  import pgmhb_pkg::*;

  localparam int RING_W = $clog2(NUM_RINGS + 1);
  localparam int SECT_W = $clog2(NUM_SECTORS + 1);
  localparam int RR_W   = 2 * RADIUS_W;
  localparam int R2_W   = 2 * COORD_W;
  localparam int CMP_W  = R2_W + 2 * RING_W + 1;
  localparam int ZSQ_W  = 2 * ZS_W;
  localparam int SQ_W   = 44;
  localparam int U_W    = 44;
  localparam int A_W    = TURN_W + 3;
  localparam int PROD_W = 32 + SECT_W;

  typedef enum logic [3:0] {
    F_IDLE, F_SQ, F_SUM, F_SCALE, F_SCALE2, F_RING, F_CORDIC, F_ANGLE,
    F_SMUL, F_SECT, F_ADDR, F_SQRT, F_PUSH
  } fstate_t;

  fstate_t state;

  logic [RADIUS_W-1:0]        max_radius;
  logic signed [HEIGHT_W-1:0] sensor_height;

  logic signed [COORD_W-1:0] x, y;
  logic signed [ZS_W-1:0]    zs;
  logic [R2_W-1:0]           xx, yy;
  logic [ZSQ_W-1:0]          zsq;
  logic [RR_W-1:0]           rr;
  logic [R2_W-1:0]           r2;
  logic [SQ_W-1:0]           d2;
  logic [CMP_W-1:0]          r2n, acc, inc;
  logic [RING_W-1:0]         k;
  logic signed [U_W-1:0]     u, v;
  logic signed [A_W-1:0]     a;
  logic [1:0]                quad;
  logic [4:0]                step;
  logic [31:0]               angle;
  logic [PROD_W-1:0]         prod;
  logic [SECT_W-1:0]         sec;
  logic [SQ_W-1:0]           sq_n, sq_res, sq_bit;
  job_t                      pend;

  logic signed [ZS_W-1:0]  uq, vq;
  logic [1:0]              quad_in;
  logic [PROD_W:0]         sec_sum;
  logic [SECT_W:0]         sec_raw;
  logic [SQ_W-1:0]         sq_sum;
  logic signed [U_W-1:0]   u_sh, v_sh;
  logic signed [A_W-1:0]   t_ext;

  assign in_ready = (state == F_IDLE);
  assign push     = (state == F_PUSH) && !full;
  assign job      = pend;

  // quadrant reduction
  always_comb begin
    if (x > 0 && y >= 0) begin
      quad_in = 2'd0; uq = ZS_W'(x);  vq = ZS_W'(y);
    end else if (x <= 0 && y > 0) begin
      quad_in = 2'd1; uq = ZS_W'(y);  vq = -ZS_W'(x);
    end else if (x < 0 && y <= 0) begin
      quad_in = 2'd2; uq = -ZS_W'(x); vq = -ZS_W'(y);
    end else begin
      quad_in = 2'd3; uq = -ZS_W'(y); vq = ZS_W'(x);
    end
  end

  assign u_sh    = u >>> step;
  assign v_sh    = v >>> step;
  assign t_ext   = $signed({3'b000, atan_turn(step)});
  assign sec_sum = (PROD_W + 1)'(prod) + (PROD_W + 1)'(33'h0_FFFF_FFFF);
  assign sec_raw = sec_sum[PROD_W:32];
  assign sq_sum  = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      max_radius    <= MAX_RADIUS_RST;
      sensor_height <= SENSOR_HEIGHT_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_RADIUS:    max_radius    <= cfg_data;
          CFG_SENSOR_HEIGHT: sensor_height <= cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            x           <= x_coord;
            y           <= y_coord;
            zs          <= ZS_W'(z_coord) + ZS_W'(sensor_height);
            pend.ring   <= '0;
            pend.sector <= '0;
            pend.zs     <= '0;
            pend.depth  <= '0;
            if (operation == OP_ADD) begin
              pend.kind <= K_NONE;
              pend.addr <= '0;
              state     <= F_SQ;
            end else if (operation == OP_CLEAR) begin
              pend.kind <= K_CLEAR;
              pend.addr <= '0;
              state     <= F_PUSH;
            end else if (operation == OP_READ && int'(ring_select) < NUM_RINGS &&
                         int'(sector_select) < NUM_SECTORS) begin
              pend.kind <= K_READ;
              pend.addr <= GRID_ADDR_W'(ring_select) * GRID_ADDR_W'(NUM_SECTORS) +
                           GRID_ADDR_W'(sector_select);
              state     <= F_PUSH;
            end else begin
              pend.kind <= K_NONE;
              pend.addr <= '0;
              state     <= F_PUSH;
            end
          end
        end
        F_SQ: begin
          xx    <= x * x;
          yy    <= y * y;
          zsq   <= zs * zs;
          rr    <= max_radius * max_radius;
          state <= F_SUM;
        end
        F_SUM: begin
          r2    <= xx + yy;
          d2    <= SQ_W'(xx) + SQ_W'(yy) + SQ_W'(zsq);
          state <= F_SCALE;
        end
        F_SCALE: begin
          r2n <= CMP_W'(r2) * CMP_W'(NUM_RINGS);
          if (CMP_W'(r2) > CMP_W'(rr)) begin
            state <= F_PUSH;
          end else begin
            state <= F_SCALE2;
          end
        end
        F_SCALE2: begin
          r2n   <= r2n * CMP_W'(NUM_RINGS);
          acc   <= CMP_W'(rr);
          inc   <= CMP_W'(rr) + CMP_W'({rr, 1'b0});
          k     <= RING_W'(1);
          state <= F_RING;
        end
        // smallest k with r2 * n^2 <= k^2 * rr, squares built by running sums
        F_RING: begin
          if (r2n <= acc) begin
            u     <= U_W'(uq) <<< 20;
            v     <= U_W'(vq) <<< 20;
            quad  <= quad_in;
            a     <= '0;
            step  <= '0;
            state <= (x == 0 && y == 0) ? F_ANGLE : F_CORDIC;
          end else begin
            k   <= k + RING_W'(1);
            acc <= acc + inc;
            inc <= inc + CMP_W'({rr, 1'b0});
          end
        end
        F_CORDIC: begin
          if (v == 0) begin
            state <= F_ANGLE;
          end else begin
            if (v > 0) begin
              u <= u + v_sh;
              v <= v - u_sh;
              a <= a + t_ext;
            end else begin
              u <= u - v_sh;
              v <= v + u_sh;
              a <= a - t_ext;
            end
            if (int'(step) == CORDIC_STEPS - 1) begin
              state <= F_ANGLE;
            end else begin
              step <= step + 5'd1;
            end
          end
        end
        F_ANGLE: begin
          if (x == 0 && y == 0) begin
            angle <= '0;
          end else if (a < 0) begin
            angle <= {quad, {TURN_W{1'b0}}};
          end else if (a > A_W'({TURN_W{1'b1}})) begin
            angle <= {quad, {TURN_W{1'b1}}};
          end else begin
            angle <= {quad, a[TURN_W-1:0]};
          end
          state <= F_SMUL;
        end
        F_SMUL: begin
          prod  <= PROD_W'(angle) * PROD_W'(NUM_SECTORS);
          state <= F_SECT;
        end
        F_SECT: begin
          if (sec_raw < (SECT_W + 1)'(1)) begin
            sec <= SECT_W'(1);
          end else if (sec_raw > (SECT_W + 1)'(NUM_SECTORS)) begin
            sec <= SECT_W'(NUM_SECTORS);
          end else begin
            sec <= sec_raw[SECT_W-1:0];
          end
          state <= F_ADDR;
        end
        F_ADDR: begin
          pend.kind   <= K_ADD;
          pend.ring   <= RING_OUT_W'(k - RING_W'(1));
          pend.sector <= SECT_OUT_W'(sec - SECT_W'(1));
          pend.zs     <= zs;
          pend.addr   <= GRID_ADDR_W'(k - RING_W'(1)) * GRID_ADDR_W'(NUM_SECTORS) +
                         GRID_ADDR_W'(sec - SECT_W'(1));
          sq_n        <= d2;
          sq_res      <= '0;
          sq_bit      <= SQ_W'(1) << (SQ_W - 2);
          state       <= F_SQRT;
        end
        // one result bit per cycle
        F_SQRT: begin
          if (sq_bit == 0) begin
            pend.depth <= sq_res[DEPTH_W-1:0];
            state      <= F_PUSH;
          end else begin
            if (sq_n >= sq_sum) begin
              sq_n   <= sq_n - sq_sum;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### sv/pgmhb_job_fifo.sv
// short job queue between front and back end
module pgmhb_job_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pgmhb_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output pgmhb_pkg::job_t head
);
  import pgmhb_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W + 1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (PTR_W + 1)'(1);
        2'b01:   count <= count - (PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/pgmhb_back.sv
// back end: grid memory, max update, reads, clear sweep and the result register
module pgmhb_back #(
  parameter int NUM_RINGS   = pgmhb_pkg::NUM_RINGS_DEF,
  parameter int NUM_SECTORS = pgmhb_pkg::NUM_SECTORS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 empty,
  input  pgmhb_pkg::job_t                      head,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 in_range,
  output logic [pgmhb_pkg::RING_OUT_W-1:0]     ring_index,
  output logic [pgmhb_pkg::SECT_OUT_W-1:0]     sector_index,
  output logic signed [pgmhb_pkg::ZS_W-1:0]    bin_height,
  output logic [pgmhb_pkg::DEPTH_W-1:0]        bin_depth,
  output logic                                 bin_filled
);
  import pgmhb_pkg::*;

  localparam int GRID   = NUM_RINGS * NUM_SECTORS;
  localparam int ADDR_W = (GRID > 1) ? $clog2(GRID) : 1;
  localparam int WORD_W = 1 + ZS_W + DEPTH_W;

  typedef enum logic [2:0] {B_INIT, B_IDLE, B_LOOK, B_CLR} bstate_t;

  typedef struct packed {
    logic                   filled;
    logic signed [ZS_W-1:0] height;
    logic [DEPTH_W-1:0]     depth;
  } bin_t;

  bstate_t           state;
  job_t              cur;
  logic [ADDR_W-1:0] sweep;
  logic [WORD_W-1:0] mem [GRID];
  bin_t              rdata;

  logic              mem_we;
  logic [ADDR_W-1:0] waddr;
  bin_t              wdata;
  logic              slot_free;
  logic              load;

  assign slot_free = !out_valid || out_ready;
  assign pop       = (state == B_IDLE) && !empty && slot_free;

  // merge for an add, zero for a sweep
  always_comb begin
    mem_we = 1'b0;
    waddr  = sweep;
    wdata  = '0;
    if (state == B_INIT || state == B_CLR) begin
      mem_we = 1'b1;
    end else if (state == B_LOOK && cur.kind == K_ADD) begin
      mem_we       = 1'b1;
      waddr        = cur.addr[ADDR_W-1:0];
      wdata.filled = 1'b1;
      wdata.height = (!rdata.filled || rdata.height < cur.zs) ? cur.zs : rdata.height;
      wdata.depth  = (!rdata.filled || rdata.depth < cur.depth) ? cur.depth : rdata.depth;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[head.addr[ADDR_W-1:0]];
  end

  assign load = (pop && head.kind == K_NONE) || (state == B_LOOK) ||
                (state == B_CLR && int'(sweep) == GRID - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_INIT, B_CLR: begin
          if (int'(sweep) == GRID - 1) begin
            sweep <= '0;
            state <= B_IDLE;
          end else begin
            sweep <= sweep + ADDR_W'(1);
          end
        end
        B_IDLE: begin
          if (pop) begin
            cur <= head;
            case (head.kind)
              K_CLEAR:        state <= B_CLR;
              K_ADD, K_READ:  state <= B_LOOK;
              default:        state <= B_IDLE;
            endcase
          end
        end
        B_LOOK: state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
      if (load) begin
        in_range     <= 1'b0;
        ring_index   <= '0;
        sector_index <= '0;
        bin_height   <= '0;
        bin_depth    <= '0;
        bin_filled   <= 1'b0;
        if (state == B_LOOK && cur.kind == K_ADD) begin
          in_range     <= 1'b1;
          ring_index   <= cur.ring;
          sector_index <= cur.sector;
        end else if (state == B_LOOK && rdata.filled) begin
          bin_height <= rdata.height;
          bin_depth  <= rdata.depth;
          bin_filled <= 1'b1;
        end
      end
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == B_IDLE))
    else $error("job taken outside idle");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> slot_free)
    else $error("result register overwritten");

  a_look_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == B_LOOK) |-> (cur.kind == K_ADD))
    else $error("grid written by a non-add job");

  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_INIT || state == B_CLR) |-> (int'(sweep) < GRID))
    else $error("sweep address beyond grid");

endmodule

### sv/polar_grid_max_height_binner.sv
// top level of the polar grid max-height binner
// an add steps through the rings one at a time, up to 30 cordic steps and a bit-serial square
//   root; a point beyond the radius is queued without the ring, angle and depth steps
// a read looks up its bin, a spare code or a read outside the grid is answered from the queue
//   without a lookup, and a clear answers after its sweep at one bin a cycle
// throughput: one item at a time in the front, the next taken the cycle after its job enters
//   the 4-job queue; reset is synchronous and sweeps all bins before the first job runs
module polar_grid_max_height_binner #(
  parameter int NUM_RINGS   = pgmhb_pkg::NUM_RINGS_DEF,
  parameter int NUM_SECTORS = pgmhb_pkg::NUM_SECTORS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [pgmhb_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [pgmhb_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // operation, x_coord, y_coord, z_coord, ring_select, sector_select
  input  logic [pgmhb_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // in_range, ring_index, sector_index, bin_height, bin_depth, bin_filled
  output logic [pgmhb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import pgmhb_pkg::*;

  logic push, full, pop, empty;
  job_t push_job, head;

  logic                    in_range, bin_filled;
  logic [RING_OUT_W-1:0]   ring_index;
  logic [SECT_OUT_W-1:0]   sector_index;
  logic signed [ZS_W-1:0]  bin_height;
  logic [DEPTH_W-1:0]      bin_depth;

  pgmhb_front #(
    .NUM_RINGS   (NUM_RINGS),
    .NUM_SECTORS (NUM_SECTORS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .operation     (s_axis_tdata[1:0]),
    .x_coord       (s_axis_tdata[21:2]),
    .y_coord       (s_axis_tdata[41:22]),
    .z_coord       (s_axis_tdata[61:42]),
    .ring_select   (s_axis_tdata[66:62]),
    .sector_select (s_axis_tdata[72:67]),
    .push          (push),
    .full          (full),
    .job           (push_job)
  );

  pgmhb_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  pgmhb_back #(
    .NUM_RINGS   (NUM_RINGS),
    .NUM_SECTORS (NUM_SECTORS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .in_range     (in_range),
    .ring_index   (ring_index),
    .sector_index (sector_index),
    .bin_height   (bin_height),
    .bin_depth    (bin_depth),
    .bin_filled   (bin_filled)
  );

  assign m_axis_tdata = {2'b00, bin_filled, bin_depth, bin_height, sector_index, ring_index,
                         in_range};

endmodule
